[hdl/tccw_pkg.sv]
package tccw_pkg;

  // field widths of the request and result channels
  localparam int KIND_W     = 2;
  localparam int CODE_W     = 21;
  localparam int RROW_W     = 6;
  localparam int RCOL_W     = 7;
  localparam int COLOR_W    = 32;
  localparam int OCOL_W     = 7;
  localparam int OROW_W     = 6;

  // configuration port
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int COLUMNS_REG_W = 8;
  localparam int ROWS_REG_W    = 7;

  localparam logic [COLUMNS_REG_W-1:0] COLUMNS_RESET = 8'd80;
  localparam logic [ROWS_REG_W-1:0]    ROWS_RESET    = 7'd25;

  // character and colour constants
  localparam logic [CODE_W-1:0]  CODE_NEWLINE   = 21'd10;
  localparam logic [CODE_W-1:0]  CODE_BACKSPACE = 21'd8;
  localparam logic [CODE_W-1:0]  CODE_SPACE     = 21'd32;
  localparam logic [COLOR_W-1:0] COLOR_WHITE    = 32'h00FF_FFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_RENDER = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS   = 2'd0,
    REG_ROWS      = 2'd1,
    REG_PEN_COLOR = 2'd2
  } cfg_reg_t;

  // datapath operations driven by one control word
  typedef enum logic [3:0] {
    OP_NOP        = 4'd0,
    OP_FETCH      = 4'd1,
    OP_TOP_SUB    = 4'd2,
    OP_CLR_SET    = 4'd3,
    OP_FILL_ALL   = 4'd4,
    OP_WR_CHAR    = 4'd5,
    OP_NEXT_ROW   = 4'd6,
    OP_SCROLL_SET = 4'd7,
    OP_FILL_ROW   = 4'd8,
    OP_TOUCH      = 4'd9,
    OP_BS_MOVE    = 4'd10,
    OP_BS_WRITE   = 4'd11,
    OP_READ       = 4'd12,
    OP_RENDER     = 4'd13,
    OP_EMIT       = 4'd14
  } uop_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEXT     = 4'd0,
    C_ALWAYS   = 4'd1,
    C_NO_REQ   = 4'd2,
    C_TOP_GE   = 4'd3,
    C_DISPATCH = 4'd4,
    C_COL_LT   = 4'd5,
    C_ROW_LT   = 4'd6,
    C_ROW_MORE = 4'd7,
    C_ALL_MORE = 4'd8,
    C_OUT_FREE = 4'd9
  } cond_t;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  // microprogram step addresses
  localparam upc_t A_INIT      = 5'd0;
  localparam upc_t A_INIT_FILL = 5'd1;
  localparam upc_t A_IDLE      = 5'd2;
  localparam upc_t A_NORM      = 5'd3;
  localparam upc_t A_DISPATCH  = 5'd4;
  localparam upc_t A_WR_CHAR   = 5'd5;
  localparam upc_t A_CHK_COL   = 5'd6;
  localparam upc_t A_NEXT_ROW  = 5'd7;
  localparam upc_t A_CHK_ROW   = 5'd8;
  localparam upc_t A_SCR_SET   = 5'd9;
  localparam upc_t A_SCR_FILL  = 5'd10;
  localparam upc_t A_TOUCH     = 5'd11;
  localparam upc_t A_BS_MOVE   = 5'd12;
  localparam upc_t A_BS_WRITE  = 5'd13;
  localparam upc_t A_CLR_SET   = 5'd14;
  localparam upc_t A_CLR_FILL  = 5'd15;
  localparam upc_t A_DONE      = 5'd16;
  localparam upc_t A_DONE_WAIT = 5'd17;
  localparam upc_t A_READ      = 5'd18;
  localparam upc_t A_RENDER    = 5'd19;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    upc_t  jump;
  } uword_t;

  // condition inputs from the datapath to the sequencer
  typedef struct packed {
    logic no_req;
    logic top_ge;
    logic col_lt;
    logic row_lt;
    logic row_more;
    logic all_more;
    logic out_free;
  } flags_t;

  // control store
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    case (a)
      A_INIT:      w = '{OP_CLR_SET,    C_NEXT,     A_IDLE};
      A_INIT_FILL: w = '{OP_FILL_ALL,   C_ALL_MORE, A_INIT_FILL};
      A_IDLE:      w = '{OP_FETCH,      C_NO_REQ,   A_IDLE};
      A_NORM:      w = '{OP_TOP_SUB,    C_TOP_GE,   A_NORM};
      A_DISPATCH:  w = '{OP_NOP,        C_DISPATCH, A_IDLE};
      A_WR_CHAR:   w = '{OP_WR_CHAR,    C_NEXT,     A_IDLE};
      A_CHK_COL:   w = '{OP_NOP,        C_COL_LT,   A_TOUCH};
      A_NEXT_ROW:  w = '{OP_NEXT_ROW,   C_NEXT,     A_IDLE};
      A_CHK_ROW:   w = '{OP_NOP,        C_ROW_LT,   A_TOUCH};
      A_SCR_SET:   w = '{OP_SCROLL_SET, C_NEXT,     A_IDLE};
      A_SCR_FILL:  w = '{OP_FILL_ROW,   C_ROW_MORE, A_SCR_FILL};
      A_TOUCH:     w = '{OP_TOUCH,      C_ALWAYS,   A_DONE};
      A_BS_MOVE:   w = '{OP_BS_MOVE,    C_NEXT,     A_IDLE};
      A_BS_WRITE:  w = '{OP_BS_WRITE,   C_ALWAYS,   A_TOUCH};
      A_CLR_SET:   w = '{OP_CLR_SET,    C_NEXT,     A_IDLE};
      A_CLR_FILL:  w = '{OP_FILL_ALL,   C_ALL_MORE, A_CLR_FILL};
      A_DONE:      w = '{OP_EMIT,       C_OUT_FREE, A_IDLE};
      A_DONE_WAIT: w = '{OP_NOP,        C_ALWAYS,   A_DONE};
      A_READ:      w = '{OP_READ,       C_ALWAYS,   A_DONE};
      A_RENDER:    w = '{OP_RENDER,     C_ALWAYS,   A_DONE};
      default:     w = '{OP_NOP,        C_ALWAYS,   A_IDLE};
    endcase
    return w;
  endfunction

  // entry step for a latched request
  function automatic upc_t dispatch(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code);
    upc_t t;
    case (kind)
      KIND_WRITE: begin
        if (code == CODE_NEWLINE) begin
          t = A_NEXT_ROW;
        end else if (code == CODE_BACKSPACE) begin
          t = A_BS_MOVE;
        end else begin
          t = A_WR_CHAR;
        end
      end
      KIND_CLEAR:  t = A_CLR_SET;
      KIND_READ:   t = A_READ;
      KIND_RENDER: t = A_RENDER;
      default:     t = A_RENDER;
    endcase
    return t;
  endfunction

endpackage

[hdl/tccw_if.sv]
// request channel
interface tccw_item_if;
  import tccw_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CODE_W-1:0]   code;
  logic [RROW_W-1:0]   read_row;
  logic [RCOL_W-1:0]   read_col;

  modport source (output valid, kind, code, read_row, read_col, input ready);
  modport sink (input valid, kind, code, read_row, read_col, output ready);
endinterface

// result channel
interface tccw_result_if;
  import tccw_pkg::*;
  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   cell_code;
  logic [COLOR_W-1:0]  cell_color;
  logic [OCOL_W-1:0]   cursor_column;
  logic [OROW_W-1:0]   cursor_line;
  logic [OROW_W-1:0]   dirty_row;
  logic                redraw_all;

  modport source (output valid, cell_code, cell_color, cursor_column, cursor_line,
                  dirty_row, redraw_all, input ready);
  modport sink (input valid, cell_code, cell_color, cursor_column, cursor_line,
                dirty_row, redraw_all, output ready);
endinterface

[hdl/text_console_cell_writer_core.sv]
// A character or backspace writes the store and moves the cursor; a character that
// wraps the row and a newline also step the row; read and render go straight to the
// result step; a scroll adds a fill of one physical row and clear a fill of the whole
// store. A row count lowered to or below the top row adds ring normalising steps once.
// One request at a time, the next taken in the idle step entered as the result is
// registered; one RAM port, a step a cycle. Reset: a clearing pass over the whole store, no request taken.
module text_console_cell_writer_core #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0]   cfg_data,
  tccw_item_if.sink                         item,
  tccw_result_if.source                     result
);
  import tccw_pkg::*;

  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CMPW  = 10;

  // configuration registers
  logic [COLUMNS_REG_W-1:0] columns;
  logic [ROWS_REG_W-1:0]    rows;
  logic [COLOR_W-1:0]       pen_color;

  // console state
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [RW-1:0] top_row;
  logic [RW-1:0] touched_row;
  logic          full_redraw;
  logic [AW-1:0] base;
  logic [AW-1:0] cnt;
  logic          rd_hit;

  // latched request
  logic [KIND_W-1:0] it_kind;
  logic [CODE_W-1:0] it_code;
  logic [RROW_W-1:0] it_rrow;
  logic [RCOL_W-1:0] it_rcol;

  // result register
  logic               res_valid;
  logic [CODE_W-1:0]  o_code;
  logic [COLOR_W-1:0] o_color;
  logic [OCOL_W-1:0]  o_col;
  logic [OROW_W-1:0]  o_row;
  logic [OROW_W-1:0]  o_dirty;
  logic               o_redraw;

  // sequencer link
  uword_t ctrl;
  flags_t flags;
  upc_t   dispatch_to;

  logic [CW-1:0] nc;
  logic [RW-1:0] nr;
  logic          out_free;
  logic          rd_ok;

  // address path
  logic [RW-1:0] a_row;
  logic [CW-1:0] a_col;
  logic [RW:0]   a_sum;
  logic [RW-1:0] a_phys;
  logic [AW-1:0] cell_addr;

  // memory port
  logic               glyph_we;
  logic               color_we;
  logic               mem_re;
  logic [AW-1:0]      mem_addr;
  logic [CODE_W-1:0]  glyph_wd;
  logic [COLOR_W-1:0] color_wd;
  logic [CODE_W-1:0]  glyph_rd;
  logic [COLOR_W-1:0] color_rd;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      columns   <= COLUMNS_RESET;
      rows      <= ROWS_RESET;
      pen_color <= COLOR_WHITE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS:   columns   <= cfg_data[COLUMNS_REG_W-1:0];
        REG_ROWS:      rows      <= cfg_data[ROWS_REG_W-1:0];
        REG_PEN_COLOR: pen_color <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // columns and rows in use, clamped to the store
  always_comb begin
    if (columns == '0) begin
      nc = CW'(1);
    end else if (CMPW'(columns) > CMPW'(MAX_COLUMNS)) begin
      nc = CW'(MAX_COLUMNS);
    end else begin
      nc = CW'(columns);
    end
    if (rows == '0) begin
      nr = RW'(1);
    end else if (CMPW'(rows) > CMPW'(MAX_ROWS)) begin
      nr = RW'(MAX_ROWS);
    end else begin
      nr = RW'(rows);
    end
  end

  assign out_free = !res_valid || result.ready;
  assign rd_ok    = (CMPW'(it_rrow) < CMPW'(nr)) && (CMPW'(it_rcol) < CMPW'(nc));

  // sequencer conditions
  assign flags.no_req   = !item.valid;
  assign flags.top_ge   = top_row >= nr;
  assign flags.col_lt   = cur_col < nc;
  assign flags.row_lt   = cur_row < nr;
  assign flags.row_more = cnt != AW'(MAX_COLUMNS - 1);
  assign flags.all_more = cnt != AW'(CELLS - 1);
  assign flags.out_free = out_free;
  assign dispatch_to    = dispatch(it_kind, it_code);

  tccw_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .flags       (flags),
    .dispatch_to (dispatch_to),
    .ctrl        (ctrl)
  );

  assign item.ready = (ctrl.op == OP_FETCH);

  // logical row to physical cell address, ring offset by the top row
  always_comb begin
    if (ctrl.op == OP_READ) begin
      a_row = RW'(it_rrow);
      a_col = CW'(it_rcol);
    end else begin
      a_row = cur_row;
      a_col = cur_col;
    end
    a_sum     = {1'b0, top_row} + {1'b0, a_row};
    a_phys    = (a_sum >= {1'b0, nr}) ? RW'(a_sum - {1'b0, nr}) : RW'(a_sum);
    cell_addr = AW'(a_phys) * AW'(MAX_COLUMNS) + AW'(a_col);
  end

  // memory port control
  always_comb begin
    glyph_we = 1'b0;
    color_we = 1'b0;
    mem_re   = 1'b0;
    mem_addr = cell_addr;
    glyph_wd = CODE_SPACE;
    color_wd = pen_color;
    case (ctrl.op)
      OP_WR_CHAR: begin
        glyph_we = 1'b1;
        color_we = 1'b1;
        glyph_wd = it_code;
      end
      OP_BS_WRITE: begin
        glyph_we = 1'b1;
      end
      OP_FILL_ROW: begin
        glyph_we = 1'b1;
        color_we = 1'b1;
        mem_addr = base + cnt;
      end
      OP_FILL_ALL: begin
        glyph_we = 1'b1;
        color_we = 1'b1;
        mem_addr = cnt;
        color_wd = COLOR_WHITE;
      end
      OP_READ: begin
        mem_re = rd_ok;
      end
      default: ;
    endcase
  end

  tccw_ram #(
    .WIDTH (CODE_W),
    .DEPTH (CELLS)
  ) u_glyph_store (
    .clk   (clk),
    .we    (glyph_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (glyph_wd),
    .rdata (glyph_rd)
  );

  tccw_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (CELLS)
  ) u_color_store (
    .clk   (clk),
    .we    (color_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (color_wd),
    .rdata (color_rd)
  );

  // cursor, ring offset and redraw tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col     <= '0;
      cur_row     <= '0;
      top_row     <= '0;
      touched_row <= '0;
      full_redraw <= 1'b1;
    end else begin
      case (ctrl.op)
        OP_FETCH: begin
          if (item.valid) begin
            if (cur_col >= nc) cur_col <= nc - 1'b1;
            if (cur_row >= nr) cur_row <= nr - 1'b1;
            if (touched_row >= nr) touched_row <= nr - 1'b1;
          end
        end
        OP_TOP_SUB: begin
          if (top_row >= nr) top_row <= top_row - nr;
        end
        OP_CLR_SET: begin
          cur_col     <= '0;
          cur_row     <= '0;
          top_row     <= '0;
          touched_row <= '0;
          full_redraw <= 1'b1;
        end
        OP_WR_CHAR: begin
          cur_col <= cur_col + 1'b1;
        end
        OP_NEXT_ROW: begin
          cur_col <= '0;
          cur_row <= cur_row + 1'b1;
        end
        OP_SCROLL_SET: begin
          top_row     <= (RW'(top_row + 1'b1) == nr) ? '0 : RW'(top_row + 1'b1);
          if (cur_row != '0) cur_row <= cur_row - 1'b1;
          full_redraw <= 1'b1;
          touched_row <= nr - 1'b1;
        end
        OP_TOUCH: begin
          if (cur_row > touched_row) touched_row <= cur_row;
        end
        OP_BS_MOVE: begin
          if (cur_col != '0) begin
            cur_col <= cur_col - 1'b1;
          end else if (cur_row != '0) begin
            cur_row <= cur_row - 1'b1;
            cur_col <= nc - 1'b1;
          end
        end
        OP_RENDER: begin
          if (full_redraw) begin
            full_redraw <= 1'b0;
            touched_row <= cur_row;
          end else if (cur_row > touched_row) begin
            touched_row <= cur_row;
          end
        end
        default: ;
      endcase
    end
  end

  // sweep counter, fill base, request latch and read hit
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_FETCH: begin
        if (item.valid) begin
          it_kind <= item.kind;
          it_code <= item.code;
          it_rrow <= item.read_row;
          it_rcol <= item.read_col;
          rd_hit  <= 1'b0;
        end
      end
      OP_CLR_SET: begin
        cnt <= '0;
      end
      OP_SCROLL_SET: begin
        cnt  <= '0;
        base <= AW'(top_row) * AW'(MAX_COLUMNS);
      end
      OP_FILL_ROW, OP_FILL_ALL: begin
        cnt <= cnt + 1'b1;
      end
      OP_READ: begin
        rd_hit <= rd_ok;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && out_free) begin
      o_code   <= rd_hit ? glyph_rd : '0;
      o_color  <= rd_hit ? color_rd : '0;
      o_col    <= OCOL_W'(cur_col);
      o_row    <= OROW_W'(cur_row);
      o_dirty  <= OROW_W'(touched_row);
      o_redraw <= full_redraw;
    end
  end

  assign result.valid         = res_valid;
  assign result.cell_code     = o_code;
  assign result.cell_color    = o_color;
  assign result.cursor_column = o_col;
  assign result.cursor_line   = o_row;
  assign result.dirty_row     = o_dirty;
  assign result.redraw_all    = o_redraw;

`ifndef SYNTHESIS
  // no store write while a new request is being taken
  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    (glyph_we || color_we) |-> !(item.valid && item.ready))
    else $error("store written during request accept");

  // an emitted result is presented on the next cycle
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_EMIT && out_free) |=> res_valid)
    else $error("emitted result not presented");

  // scroll fill stays inside one physical row
  a_row_fill_in_row: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_FILL_ROW) |-> (cnt < AW'(MAX_COLUMNS)))
    else $error("scroll fill ran past its row");

  // ring offset is normalised before any cell access
  a_top_in_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.cond == C_DISPATCH) |-> (top_row < nr))
    else $error("top row out of range at dispatch");

  // read data only ever returned for a read request
  a_hit_only_read: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_EMIT && rd_hit) |-> (it_kind == KIND_READ))
    else $error("cell data returned for a non-read request");
`endif

endmodule

[hdl/tccw_ram.sv]
module tccw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[hdl/tccw_seq.sv]
module tccw_seq (
  input  logic             clk,
  input  logic             rst,
  input  tccw_pkg::flags_t flags,
  input  tccw_pkg::upc_t   dispatch_to,
  output tccw_pkg::uword_t ctrl
);
  import tccw_pkg::*;

  upc_t upc;
  upc_t upc_next;
  logic take;

  // control word of the current step
  assign ctrl = ucode(upc);

  // jump condition select
  always_comb begin
    case (ctrl.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_REQ:   take = flags.no_req;
      C_TOP_GE:   take = flags.top_ge;
      C_DISPATCH: take = 1'b1;
      C_COL_LT:   take = flags.col_lt;
      C_ROW_LT:   take = flags.row_lt;
      C_ROW_MORE: take = flags.row_more;
      C_ALL_MORE: take = flags.all_more;
      C_OUT_FREE: take = flags.out_free;
      default:    take = 1'b0;
    endcase
  end

  // next step address
  always_comb begin
    if (ctrl.cond == C_DISPATCH) begin
      upc_next = dispatch_to;
    end else if (take) begin
      upc_next = ctrl.jump;
    end else begin
      upc_next = upc_t'(upc + 1'b1);
    end
  end

  // step counter, starts with the store clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= A_INIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

[sim/text_console_cell_writer_core_tb.sv]
module text_console_cell_writer_core_tb;
  import tccw_pkg::*;

  localparam int MAX_COLUMNS  = 128;
  localparam int MAX_ROWS     = 64;
  localparam int CELLS        = MAX_COLUMNS * MAX_ROWS;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 200;
  localparam int DRAIN_CYCLES = 20;

  // register settings per phase, phase 0 keeps the reset values
  localparam logic [COLUMNS_REG_W-1:0] PHASE_COLS [PHASES] = '{
    8'd80, 8'd1, 8'd0, 8'd128, 8'd255, 8'd8, 8'd3, 8'd80, 8'd17};
  localparam logic [ROWS_REG_W-1:0] PHASE_ROWS [PHASES] = '{
    7'd25, 7'd1, 7'd0, 7'd64, 7'd127, 7'd4, 7'd2, 7'd25, 7'd70};

  typedef struct {
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] colour;
    logic [OCOL_W-1:0]  column;
    logic [OROW_W-1:0]  line;
    logic [OROW_W-1:0]  dirty;
    logic               redraw;
  } console_result_t;

  // shadow of the console: cell store, cursor, scroll offset and redraw marks
  class console_scoreboard;
    logic [COLUMNS_REG_W-1:0] columns;
    logic [ROWS_REG_W-1:0]    rows;
    logic [COLOR_W-1:0]       pen;
    logic [CODE_W-1:0]        glyphs [CELLS];
    logic [COLOR_W-1:0]       colours [CELLS];
    logic [OROW_W-1:0]        top_row;
    logic [OROW_W-1:0]        cur_row;
    logic [OROW_W-1:0]        touched_row;
    logic [OCOL_W-1:0]        cur_col;
    logic                     full_redraw;
    console_result_t          due [$];
    int                       errors;

    function void power_on();
      columns     = COLUMNS_RESET;
      rows        = ROWS_RESET;
      pen         = COLOR_WHITE;
      top_row     = '0;
      cur_row     = '0;
      cur_col     = '0;
      touched_row = '0;
      full_redraw = 1'b1;
      errors      = 0;
      wipe();
    endfunction

    function int used_cols();
      if (columns == 0) return 1;
      if (int'(columns) > MAX_COLUMNS) return MAX_COLUMNS;
      return int'(columns);
    endfunction

    function int used_rows();
      if (rows == 0) return 1;
      if (int'(rows) > MAX_ROWS) return MAX_ROWS;
      return int'(rows);
    endfunction

    // logical row is offset by the ring top row
    function int cell_index(int row, int col);
      int phys;
      phys = (int'(top_row) + row) % used_rows();
      return (phys * MAX_COLUMNS + col % MAX_COLUMNS) % CELLS;
    endfunction

    function void wipe();
      for (int i = 0; i < CELLS; i++) begin
        glyphs[i]  = CODE_SPACE;
        colours[i] = COLOR_WHITE;
      end
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_COLUMNS:   columns = value[COLUMNS_REG_W-1:0];
        REG_ROWS:      rows = value[ROWS_REG_W-1:0];
        REG_PEN_COLOR: pen = value;
        default: ;
      endcase
    endfunction

    // cursor stays on the last row, the old top row becomes the blank bottom row
    function void scroll_up();
      int nr;
      int base;
      nr = used_rows();
      top_row = OROW_W'((int'(top_row) + 1) % nr);
      base = ((int'(top_row) + nr - 1) % nr) * MAX_COLUMNS;
      for (int x = 0; x < MAX_COLUMNS; x++) begin
        glyphs[base + x]  = CODE_SPACE;
        colours[base + x] = pen;
      end
      full_redraw = 1'b1;
      touched_row = OROW_W'(nr - 1);
    endfunction

    function void next_row();
      cur_col = '0;
      if (int'(cur_row) + 1 >= used_rows()) begin
        scroll_up();
      end else begin
        cur_row = cur_row + 1'b1;
      end
    endfunction

    function void write_code(logic [CODE_W-1:0] code);
      int idx;
      if (code == CODE_NEWLINE) begin
        next_row();
      end else if (code == CODE_BACKSPACE) begin
        // step back across the row boundary, blank the glyph only
        if (cur_col > 0) begin
          cur_col = cur_col - 1'b1;
        end else if (cur_row > 0) begin
          cur_row = cur_row - 1'b1;
          cur_col = OCOL_W'(used_cols() - 1);
        end
        glyphs[cell_index(int'(cur_row), int'(cur_col))] = CODE_SPACE;
      end else begin
        idx = cell_index(int'(cur_row), int'(cur_col));
        glyphs[idx]  = code;
        colours[idx] = pen;
        if (int'(cur_col) + 1 >= used_cols()) begin
          next_row();
        end else begin
          cur_col = cur_col + 1'b1;
        end
      end
      if (cur_row > touched_row) touched_row = cur_row;
    endfunction

    // apply an accepted request and queue the result it should give
    function void take_request(kind_t kind, logic [CODE_W-1:0] code,
                               logic [RROW_W-1:0] rd_row, logic [RCOL_W-1:0] rd_col);
      console_result_t want;
      int nr;
      int nc;
      int idx;
      nr = used_rows();
      nc = used_cols();
      want.code   = '0;
      want.colour = '0;
      // a shrunk screen pulls the cursor and marks back inside
      top_row = OROW_W'(int'(top_row) % nr);
      if (int'(cur_col) >= nc) cur_col = OCOL_W'(nc - 1);
      if (int'(cur_row) >= nr) cur_row = OROW_W'(nr - 1);
      if (int'(touched_row) >= nr) touched_row = OROW_W'(nr - 1);
      case (kind)
        KIND_WRITE: write_code(code);
        KIND_CLEAR: begin
          wipe();
          top_row     = '0;
          cur_col     = '0;
          cur_row     = '0;
          touched_row = '0;
          full_redraw = 1'b1;
        end
        KIND_READ: begin
          if (int'(rd_row) < nr && int'(rd_col) < nc) begin
            idx = cell_index(int'(rd_row), int'(rd_col));
            want.code   = glyphs[idx];
            want.colour = colours[idx];
          end
        end
        default: begin
          if (full_redraw) begin
            full_redraw = 1'b0;
            touched_row = '0;
          end
          if (cur_row > touched_row) touched_row = cur_row;
        end
      endcase
      want.column = cur_col;
      want.line   = cur_row;
      want.dirty  = touched_row;
      want.redraw = full_redraw;
      due.push_back(want);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(console_result_t got);
      console_result_t want;
      if (due.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = due.pop_front();
      compare("cell_code", 32'(want.code), 32'(got.code));
      compare("cell_color", want.colour, got.colour);
      compare("cursor_column", 32'(want.column), 32'(got.column));
      compare("cursor_line", 32'(want.line), 32'(got.line));
      compare("dirty_row", 32'(want.dirty), 32'(got.dirty));
      compare("redraw_all", 32'(want.redraw), 32'(got.redraw));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    sender_idle;
  int                    receiver_idle;
  console_scoreboard     sb;

  tccw_item_if   item ();
  tccw_result_if result ();

  text_console_cell_writer_core #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (item),
    .result   (result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= receiver_idle);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      sb.check_result('{result.cell_code, result.cell_color, result.cursor_column,
                        result.cursor_line, result.dirty_row, result.redraw_all});
    end
  end

  // all three registers, one write per cycle, block idle
  task automatic configure(logic [COLUMNS_REG_W-1:0] cols, logic [ROWS_REG_W-1:0] nrows,
                           logic [COLOR_W-1:0] pen);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_data  <= CFG_DATA_W'(cols);
    @(posedge clk);
    sb.set_reg(REG_COLUMNS, CFG_DATA_W'(cols));
    cfg_index <= REG_ROWS;
    cfg_data  <= CFG_DATA_W'(nrows);
    @(posedge clk);
    sb.set_reg(REG_ROWS, CFG_DATA_W'(nrows));
    cfg_index <= REG_PEN_COLOR;
    cfg_data  <= pen;
    @(posedge clk);
    sb.set_reg(REG_PEN_COLOR, pen);
    cfg_we <= 1'b0;
  endtask

  // one request, with a random gap before it
  task automatic send_request(kind_t kind, logic [CODE_W-1:0] code,
                              logic [RROW_W-1:0] rd_row, logic [RCOL_W-1:0] rd_col);
    if ($urandom_range(99) < sender_idle) begin
      item.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    item.valid    <= 1'b1;
    item.kind     <= kind;
    item.code     <= code;
    item.read_row <= rd_row;
    item.read_col <= rd_col;
    do @(posedge clk); while (!item.ready);
    sb.take_request(kind, code, rd_row, rd_col);
  endtask

  // mostly text with newlines and backspaces, some reads, few renders and clears
  task automatic random_request();
    kind_t              kind;
    logic [CODE_W-1:0]  code;
    logic [RROW_W-1:0]  rd_row;
    logic [RCOL_W-1:0]  rd_col;
    int                 pick;
    int                 nr;
    int                 nc;
    pick   = $urandom_range(99);
    nr     = sb.used_rows();
    nc     = sb.used_cols();
    code   = CODE_W'($urandom);
    rd_row = RROW_W'($urandom);
    rd_col = RCOL_W'($urandom);
    if (pick < 80) begin
      kind = KIND_WRITE;
      pick = $urandom_range(99);
      if (pick < 10) begin
        code = CODE_NEWLINE;
      end else if (pick < 22) begin
        code = CODE_BACKSPACE;
      end else if (pick < 92) begin
        code = CODE_W'($urandom_range(32, 126));
      end
    end else if (pick < 93) begin
      kind = KIND_READ;
      // most reads land on the screen, half of those on the cursor row
      if ($urandom_range(3) != 0) begin
        rd_col = RCOL_W'($urandom_range(nc - 1));
        if ($urandom_range(1) == 0) begin
          rd_row = (int'(sb.cur_row) < nr) ? sb.cur_row : RROW_W'(nr - 1);
        end else begin
          rd_row = RROW_W'($urandom_range(nr - 1));
        end
      end
    end else if (pick < 99) begin
      kind = KIND_RENDER;
    end else begin
      kind = KIND_CLEAR;
    end
    send_request(kind, code, rd_row, rd_col);
  endtask

  task automatic wait_drained();
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    sb = new;
    sb.power_on();
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_COLUMNS;
    cfg_data        <= '0;
    item.valid      <= 1'b0;
    item.kind       <= KIND_WRITE;
    item.code       <= '0;
    item.read_row   <= '0;
    item.read_col   <= '0;
    sender_idle   = 30;
    receiver_idle = 85;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: top-left backspace, field extremes, row wrap, reads off screen
    send_request(KIND_WRITE, CODE_BACKSPACE, '0, '0);
    send_request(KIND_RENDER, '0, '0, '0);
    send_request(KIND_READ, '0, '0, '0);
    send_request(KIND_WRITE, 21'd72, '0, '0);
    send_request(KIND_WRITE, 21'd0, '0, '0);
    send_request(KIND_WRITE, 21'h10FFFF, '0, '0);
    send_request(KIND_WRITE, 21'h1FFFFF, '0, '0);
    send_request(KIND_READ, '0, '0, 7'd1);
    send_request(KIND_READ, '0, '0, 7'd3);
    send_request(KIND_WRITE, CODE_NEWLINE, '0, '0);
    send_request(KIND_WRITE, CODE_BACKSPACE, '0, '0);
    send_request(KIND_WRITE, 21'd120, '0, '0);
    send_request(KIND_READ, '0, '0, 7'd79);
    send_request(KIND_READ, '0, 6'd24, 7'd79);
    send_request(KIND_READ, '0, 6'd25, 7'd0);
    send_request(KIND_READ, '0, 6'd0, 7'd80);
    send_request(KIND_READ, '0, 6'd63, 7'd127);
    send_request(KIND_RENDER, '0, '0, '0);
    send_request(KIND_CLEAR, '0, '0, '0);
    send_request(KIND_READ, '0, '0, '0);
    send_request(KIND_RENDER, '0, '0, '0);

    // random phases over several screen sizes and idling patterns
    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        sender_idle   = 30;
        receiver_idle = 85;
      end else if (p < 6) begin
        sender_idle   = 85;
        receiver_idle = 30;
      end else begin
        sender_idle   = 0;
        receiver_idle = 0;
      end
      if (p > 0) begin
        item.valid <= 1'b0;
        wait_drained();
        configure(PHASE_COLS[p], PHASE_ROWS[p],
                  (p == 1) ? 32'h0 : (p == 2) ? 32'hFFFF_FFFF : COLOR_W'($urandom));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_request();
      end
    end
    item.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
